>>> sv/ps2mt_pkg.sv
package ps2mt_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_W          = 13;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;

    localparam logic [7:0] ACK_BYTE   = 8'hFA;
    localparam logic [7:0] SYNC_MASK  = 8'hC8;
    localparam logic [7:0] SYNC_VALUE = 8'h08;

    // header bit positions
    localparam int BTN_W     = 3;
    localparam int XSIGN_POS = 4;
    localparam int YSIGN_POS = 5;

    localparam int MOVE_X_W = 9;
    localparam int MOVE_Y_W = 10;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd768;
    localparam int CURSOR_RST_X = 512;
    localparam int CURSOR_RST_Y = 384;

    typedef enum logic [1:0] {
        EV_RELEASED = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_MOVED    = 2'd2,
        EV_DRAGGED  = 2'd3
    } t_event_kind;

endpackage

>>> sv/ps2mt_clamp.sv
// Adds a signed delta to one cursor coordinate and clamps it to 0..size-1,
// with the size itself limited to 1..2^COORD_BITS.
module ps2mt_clamp
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]      i_cursor,
    input  logic signed [MOVE_Y_W-1:0] i_delta,
    input  logic [CFG_W-1:0]           i_size,
    output logic [COORD_BITS-1:0]      o_next
);

    localparam int SZW  = (CFG_W > COORD_BITS + 1) ? CFG_W : COORD_BITS + 1;
    localparam int SUMW = COORD_BITS + 2;
    localparam logic [SZW-1:0] LIMIT = SZW'(1) << COORD_BITS;

    logic [SZW-1:0]         size_ext;
    logic [SZW-1:0]         max_coord;
    logic signed [SUMW-1:0] sum;
    logic [SZW-1:0]         sum_ext;

    always_comb begin
        size_ext = SZW'(i_size);
        if (size_ext == '0) begin
            max_coord = '0;
        end else if (size_ext > LIMIT) begin
            max_coord = LIMIT - SZW'(1);
        end else begin
            max_coord = size_ext - SZW'(1);
        end

        sum     = $signed({2'b00, i_cursor}) + SUMW'(i_delta);
        sum_ext = SZW'(sum[COORD_BITS:0]);

        if (sum[SUMW-1]) begin
            o_next = '0;
        end else if (sum_ext > max_coord) begin
            o_next = max_coord[COORD_BITS-1:0];
        end else begin
            o_next = sum[COORD_BITS-1:0];
        end
    end

endmodule

>>> sv/ps2_mouse_packet_tracker.sv
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_rx_byte
// out      output     o_out_valid / i_out_ready o_pos_x o_pos_y o_buttons o_event_kind
//                                               o_move_x o_move_y
// cfg      input      APB psel/penable/pready   screen_width @0, screen_height @4
//
// One byte per cycle sustained while the result side is not stalled; an input transaction
// reaches the result through the input register, then decode/add/clamp into the result register.
// Bytes that do not close a packet leave the input register without a result.
// Synchronous active-low reset: phase back to awaiting acknowledge, cursor to
// screen center of the default size, sizes to 1024 x 768.
// A stalled result only blocks the input register when it holds a third byte.
module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_rx_byte,

    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [COORD_BITS-1:0]      o_pos_x,
    output logic [COORD_BITS-1:0]      o_pos_y,
    output logic [BTN_W-1:0]           o_buttons,
    output logic [1:0]                 o_event_kind,
    output logic signed [MOVE_X_W-1:0] o_move_x,
    output logic signed [MOVE_Y_W-1:0] o_move_y,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int CMAX = (1 << COORD_BITS) - 1;
    localparam logic [COORD_BITS-1:0] RST_X =
        COORD_BITS'((CURSOR_RST_X > CMAX) ? CMAX : CURSOR_RST_X);
    localparam logic [COORD_BITS-1:0] RST_Y =
        COORD_BITS'((CURSOR_RST_Y > CMAX) ? CMAX : CURSOR_RST_Y);

    typedef enum logic [1:0] {
        PH_ACK  = 2'd0,
        PH_HEAD = 2'd1,
        PH_X    = 2'd2,
        PH_Y    = 2'd3
    } t_phase;

    // configuration
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_height <= pwdata[CFG_W-1:0];
            end else begin
                r_width  <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? APB_DW'(r_height) : APB_DW'(r_width);

    // pipeline registers and packet state
    t_phase                     r_phase, n_phase;
    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic [7:0]                 r_header, n_header;
    logic [7:0]                 r_xbyte, n_xbyte;
    logic [COORD_BITS-1:0]      r_cur_x, r_cur_y;
    logic                       r_out_valid;
    logic [BTN_W-1:0]           r_buttons;
    t_event_kind                r_kind, n_kind;
    logic signed [MOVE_X_W-1:0] r_move_x;
    logic signed [MOVE_Y_W-1:0] r_move_y;

    logic                       produce;
    logic                       out_free;
    logic                       adv;
    logic                       in_acc;
    logic signed [MOVE_X_W-1:0] dx;
    logic signed [MOVE_X_W-1:0] dy_raw;
    logic signed [MOVE_Y_W-1:0] dy;
    logic [BTN_W-1:0]           btn;
    logic [COORD_BITS-1:0]      next_x, next_y;

    assign produce    = r_in_valid && (r_phase == PH_Y);
    assign out_free   = !r_out_valid || i_out_ready;
    assign adv        = r_in_valid && (!produce || out_free);
    assign o_in_ready = !r_in_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign btn    = r_header[BTN_W-1:0];
    assign dx     = $signed({r_header[XSIGN_POS], r_xbyte});
    assign dy_raw = $signed({r_header[YSIGN_POS], r_in_byte});
    assign dy     = -MOVE_Y_W'(dy_raw);

    always_comb begin
        n_phase  = r_phase;
        n_header = r_header;
        n_xbyte  = r_xbyte;
        unique case (r_phase)
            PH_ACK: begin
                if (r_in_byte == ACK_BYTE) n_phase = PH_HEAD;
            end
            PH_HEAD: begin
                if ((r_in_byte & SYNC_MASK) == SYNC_VALUE) begin
                    n_header = r_in_byte;
                    n_phase  = PH_X;
                end
            end
            PH_X: begin
                n_xbyte = r_in_byte;
                n_phase = PH_Y;
            end
            PH_Y: begin
                n_phase = PH_HEAD;
            end
            default: n_phase = PH_ACK;
        endcase

        if ((dx == '0) && (dy_raw == '0)) begin
            n_kind = (btn == '0) ? EV_RELEASED : EV_PRESSED;
        end else begin
            n_kind = (btn == '0) ? EV_MOVED : EV_DRAGGED;
        end
    end

    ps2mt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .i_cursor (r_cur_x),
        .i_delta  (MOVE_Y_W'(dx)),
        .i_size   (r_width),
        .o_next   (next_x)
    );

    ps2mt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .i_cursor (r_cur_y),
        .i_delta  (dy),
        .i_size   (r_height),
        .o_next   (next_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ACK;
            r_in_valid  <= 1'b0;
            r_header    <= '0;
            r_xbyte     <= '0;
            r_cur_x     <= RST_X;
            r_cur_y     <= RST_Y;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_rx_byte;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (adv) begin
                r_phase  <= n_phase;
                r_header <= n_header;
                r_xbyte  <= n_xbyte;
            end

            if (adv && produce) begin
                r_cur_x     <= next_x;
                r_cur_y     <= next_y;
                r_out_valid <= 1'b1;
                r_buttons   <= btn;
                r_kind      <= n_kind;
                r_move_x    <= dx;
                r_move_y    <= dy;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pos_x      = r_cur_x;
    assign o_pos_y      = r_cur_y;
    assign o_buttons    = r_buttons;
    assign o_event_kind = r_kind;
    assign o_move_x     = r_move_x;
    assign o_move_y     = r_move_y;

    // a completed packet always resyncs on the next header
    a_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && produce |=> r_phase == PH_HEAD)
        else $error("phase not back to header after packet");

    // input side stalls only behind a held third byte and a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_phase == PH_Y && r_out_valid)
        else $error("input stalled without cause");

    a_kind_btn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_event_kind[0] == (o_buttons != '0))
        else $error("event kind disagrees with buttons");

    a_kind_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_move_x == '0) && (o_move_y == '0) |->
            (o_event_kind == EV_RELEASED) || (o_event_kind == EV_PRESSED))
        else $error("still packet classified as movement");

endmodule

>>> dv/ps2_mouse_packet_tracker_tb.sv
`timescale 1ns / 100ps

module ps2_mouse_packet_tracker_tb;
    import ps2mt_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int DRAIN_CYCLES  = 4;     // margin past the input and result registers
    localparam int LONG_HOLD     = 80;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int COORD_LIMIT   = 1 << COORD_BITS_DEF;

    localparam logic [APB_AW-1:0] REG_WIDTH_ADDR  = 3'd0;
    localparam logic [APB_AW-1:0] REG_HEIGHT_ADDR = 3'd4;

    typedef enum logic [1:0] {
        PH_WAIT_ACK = 2'd0,
        PH_HEADER   = 2'd1,
        PH_X        = 2'd2,
        PH_Y        = 2'd3
    } t_trk_phase;

    typedef struct {
        logic [COORD_BITS_DEF-1:0] pos_x;
        logic [COORD_BITS_DEF-1:0] pos_y;
        logic [BTN_W-1:0]          buttons;
        t_event_kind               kind;
        logic signed [MOVE_X_W-1:0] move_x;
        logic signed [MOVE_Y_W-1:0] move_y;
    } t_mouse_report;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [7:0]                 i_rx_byte = 8'h00;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [COORD_BITS_DEF-1:0]  o_pos_x;
    logic [COORD_BITS_DEF-1:0]  o_pos_y;
    logic [BTN_W-1:0]           o_buttons;
    logic [1:0]                 o_event_kind;
    logic signed [MOVE_X_W-1:0] o_move_x;
    logic signed [MOVE_Y_W-1:0] o_move_y;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_AW-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    // tracker model state
    t_trk_phase       trk_phase = PH_WAIT_ACK;
    logic [7:0]       trk_header = 8'h00;
    logic [7:0]       trk_x = 8'h00;
    int               cursor_x = CURSOR_RST_X;
    int               cursor_y = CURSOR_RST_Y;
    logic [CFG_W-1:0] scr_width = WIDTH_RST;
    logic [CFG_W-1:0] scr_height = HEIGHT_RST;

    t_mouse_report pending_reports[$];
    int            err_count = 0;
    int            idle_cycles = 0;
    bit            in_gaps_on = 1'b0;
    bit            out_stalls_on = 1'b0;
    bit            long_hold_req = 1'b0;

    ps2_mouse_packet_tracker DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_buttons    (o_buttons),
        .o_event_kind (o_event_kind),
        .o_move_x     (o_move_x),
        .o_move_y     (o_move_y),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int screen_limit(logic [CFG_W-1:0] size);
        int s;
        s = int'(size);
        if (s < 1) s = 1;
        if (s > COORD_LIMIT) s = COORD_LIMIT;
        return s;
    endfunction

    function automatic int clamp_coord(int v, int size);
        if (v < 0) return 0;
        if (v > size - 1) return size - 1;
        return v;
    endfunction

    // advance the tracker on one accepted byte; queue a report on the third byte
    task automatic track_byte(input logic [7:0] b);
        int dx;
        int dy;
        logic [BTN_W-1:0] btn;
        t_mouse_report rep;
        case (trk_phase)
            PH_WAIT_ACK: begin
                if (b == ACK_BYTE) trk_phase = PH_HEADER;
            end
            PH_HEADER: begin
                if ((b & SYNC_MASK) == SYNC_VALUE) begin
                    trk_header = b;
                    trk_phase = PH_X;
                end
            end
            PH_X: begin
                trk_x = b;
                trk_phase = PH_Y;
            end
            default: begin
                trk_phase = PH_HEADER;
                btn = trk_header[BTN_W-1:0];
                dx = int'(trk_x);
                dy = int'(b);
                if (trk_header[XSIGN_POS]) dx -= 256;
                if (trk_header[YSIGN_POS]) dy -= 256;
                dy = -dy;
                if (dx == 0 && dy == 0)
                    rep.kind = (btn == 0) ? EV_RELEASED : EV_PRESSED;
                else
                    rep.kind = (btn == 0) ? EV_MOVED : EV_DRAGGED;
                cursor_x = clamp_coord(cursor_x + dx, screen_limit(scr_width));
                cursor_y = clamp_coord(cursor_y + dy, screen_limit(scr_height));
                rep.pos_x = COORD_BITS_DEF'(cursor_x);
                rep.pos_y = COORD_BITS_DEF'(cursor_y);
                rep.buttons = btn;
                rep.move_x = MOVE_X_W'(dx);
                rep.move_y = MOVE_Y_W'(dy);
                pending_reports.push_back(rep);
            end
        endcase
    endtask

    task automatic field_check(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic check_report();
        t_mouse_report rep;
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual pos %0d,%0d",
                     $time, o_pos_x, o_pos_y);
            err_count++;
        end else begin
            rep = pending_reports.pop_front();
            field_check("pos_x", rep.pos_x, o_pos_x);
            field_check("pos_y", rep.pos_y, o_pos_y);
            field_check("buttons", rep.buttons, o_buttons);
            field_check("event_kind", rep.kind, o_event_kind);
            field_check("move_x", rep.move_x, o_move_x);
            field_check("move_y", rep.move_y, o_move_y);
        end
    endtask

    // transaction monitor: results are checked before the same-edge input is tracked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_report();
            if (i_in_valid && o_in_ready) track_byte(i_rx_byte);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired, %0d reports outstanding",
                     $time, pending_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // result-side ready: random stall bursts, or one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
    endtask

    // let the clock advance first so the monitor has seen the last accepted byte
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        logic [APB_DW-1:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == REG_WIDTH_ADDR) scr_width = data[CFG_W-1:0];
        else scr_height = data[CFG_W-1:0];
        // read back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd != APB_DW'(data[CFG_W-1:0])) begin
            $display("%0t: readback mismatch at %0d, expected %0d, actual %0d",
                     $time, addr, data[CFG_W-1:0], rd);
            err_count++;
        end
    endtask

    task automatic set_screen(input int w, input int h);
        wait_drain();
        reg_write(REG_WIDTH_ADDR, w);
        reg_write(REG_HEIGHT_ADDR, h);
    endtask

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_header();
        return SYNC_VALUE | (8'($urandom) & 8'h37);
    endfunction

    task automatic random_packets(input int n_pkts);
        for (int i = 0; i < n_pkts; i++) send_packet(rand_header(), pick_delta(), pick_delta());
    endtask

    // bytes before the acknowledge are dropped, including valid-looking headers
    task automatic test_ack_wait();
        send_byte(8'h08);
        send_byte(8'h00);
        send_byte(8'hFB);
        send_byte(8'hFF);
        send_byte(ACK_BYTE);
        wait_drain();
    endtask

    task automatic test_packet_kinds();
        send_packet(8'h08, 8'h00, 8'h00);       // released
        send_packet(8'h09, 8'h00, 8'h00);       // pressed, left
        send_packet(8'h0E, 8'h00, 8'h00);       // pressed, right + middle
        send_packet(8'h08, 8'h05, 8'h03);       // moved
        send_packet(8'h3F, 8'hFF, 8'hFF);       // dragged, dx = -1, dy up to +1
        send_packet(8'h38, 8'h00, 8'h00);       // most negative, dy up to +256
        send_packet(8'h08, 8'hFF, 8'hFF);       // most positive
        // out-of-sync bytes in header position are skipped
        send_byte(8'hC8);
        send_byte(8'h00);
        send_byte(8'h48);
        send_byte(ACK_BYTE);
        send_packet(8'h0A, 8'h80, 8'h7F);
        wait_drain();
    endtask

    task automatic test_screen_sizes();
        set_screen(1, 1);
        random_packets(6);
        set_screen(4096, 4096);
        random_packets(12);
        set_screen(0, 0);                       // treated as 1 x 1
        random_packets(4);
        set_screen(8191, 8191);                 // treated as full range
        random_packets(12);
        set_screen(4097, 2);
        random_packets(6);
        // size change between header/X and the closing byte
        set_screen(640, 480);
        send_byte(8'h08);
        send_byte(8'hFF);
        wait_drain();
        reg_write(REG_WIDTH_ADDR, 100);
        reg_write(REG_HEIGHT_ADDR, 50);
        send_byte(8'h00);
        random_packets(4);
        wait_drain();
    endtask

    task automatic test_backpressure();
        in_gaps_on = 1'b0;
        long_hold_req = 1'b1;
        random_packets(12);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n_bytes, input bit with_idle);
        int sent;
        logic [7:0] b;
        in_gaps_on = with_idle;
        out_stalls_on = with_idle;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(0, 9) == 0) begin
                b = 8'($urandom_range(0, 255));
                // mostly keep noise out of sync
                if ($urandom_range(0, 3) != 0 && (b & SYNC_MASK) == SYNC_VALUE) b[7] = 1'b1;
                send_byte(b);
                sent++;
            end else begin
                send_packet(rand_header(), pick_delta(), pick_delta());
                sent += 3;
            end
            if (with_idle && $urandom_range(0, 19) == 0) begin
                in_gaps_on = ~in_gaps_on;
                out_stalls_on = ~out_stalls_on;
            end
        end
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ack_wait();
        test_packet_kinds();
        test_screen_sizes();
        test_backpressure();

        set_screen(1024, 768);
        test_random_traffic(150, 1'b1);
        set_screen($urandom_range(1, 64), $urandom_range(1, 64));
        test_random_traffic(100, 1'b1);
        set_screen($urandom_range(1, 8191), $urandom_range(1, 8191));
        test_random_traffic(100, 1'b1);
        set_screen(4096, 1);
        test_random_traffic(80, 1'b1);
        set_screen(1920, 1080);
        test_random_traffic(120, 1'b0);

        wait_drain();
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
